// ===== hw/rtl/ris_pkg.sv =====
// ----------------------------------------------------------------------------
// ris_pkg: shared types and constants of the record insertion sorter
// Item structs for both channels, the stored record, the controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ris_pkg;

    localparam int NAME_HEAD_W = 64;
    localparam int NAME_TAIL_W = 8;
    localparam int NAME_W      = NAME_HEAD_W + NAME_TAIL_W;
    localparam int NAME_BYTES  = NAME_W / 8;
    localparam int AGE_W       = 8;
    localparam int PHONE_W     = 31;
    localparam int POS_W       = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SORT_KEY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 1'b1;

    typedef struct packed {
        logic [NAME_HEAD_W-1:0] name_head;
        logic [NAME_TAIL_W-1:0] name_tail;
        logic [AGE_W-1:0]       age;
        logic [PHONE_W-1:0]     phone;
        logic                   is_last;
    } rec_in_t;

    typedef struct packed {
        logic [POS_W-1:0]       position;
        logic [NAME_HEAD_W-1:0] out_name_head;
        logic [NAME_TAIL_W-1:0] out_name_tail;
        logic [AGE_W-1:0]       out_age;
        logic [PHONE_W-1:0]     out_phone;
        logic                   overflowed;
        logic                   last_of_run;
    } res_out_t;

    typedef struct packed {
        logic [NAME_HEAD_W-1:0] name_head;
        logic [NAME_TAIL_W-1:0] name_tail;
        logic [AGE_W-1:0]       age;
        logic [PHONE_W-1:0]     phone;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } ris_state_t;

    typedef struct packed {
        logic latch_in;    // capture the accepted item
        logic set_drop;    // store full: flag the set
        logic start_scan;  // point at the tail, read the last entry
        logic scan_step;   // move the read entry up one, read the next one down
        logic place;       // write the new record, count it
        logic emit_read;   // read the entry for the next result
        logic emit_load;   // load the result register
        logic clear_set;   // empty the store, clear the flag
    } ris_cmd_t;

    typedef struct packed {
        logic full;
        logic fill_zero;
        logic p_one;
        logic ahead;
        logic rec_last;
        logic item_last;
        logic emit_last;
        logic out_free;
    } ris_sts_t;

endpackage

// ===== hw/rtl/ris_ctrl.sv =====
// ----------------------------------------------------------------------------
// ris_ctrl: sequencer of the record insertion sorter
// Steps each record through the tail-first scan and placement, then walks the
// store out through the result register when a set closes.
// ----------------------------------------------------------------------------
module ris_ctrl
    import ris_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rec_valid,
    output logic     rec_ready,
    input  ris_sts_t sts,
    output ris_cmd_t cmd
);

    ris_state_t state_reg;
    ris_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rec_valid)
                begin
                    priority if (sts.full)
                        state_next = sts.rec_last ? ST_EMIT_RD : ST_IDLE;
                    else if (sts.fill_zero)
                        state_next = ST_PLACE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!sts.ahead || sts.p_one)
                    state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                state_next = sts.item_last ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                if (sts.out_free)
                    state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        rec_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rec_ready = 1'b1;
                if (rec_valid)
                begin
                    cmd.latch_in = 1'b1;
                    if (sts.full)
                        cmd.set_drop = 1'b1;
                    else
                        cmd.start_scan = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = sts.ahead;
            end
            ST_PLACE:
            begin
                cmd.place = 1'b1;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_read = sts.out_free;
            end
            ST_EMIT_LD:
            begin
                cmd.emit_load = 1'b1;
                cmd.clear_set = sts.emit_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ris_datapath.sv =====
// ----------------------------------------------------------------------------
// ris_datapath: record store, counters and comparator of the sorter
// Single-port-read record memory, fill, insertion and output counters, the
// age or name comparator and the result register.
// ----------------------------------------------------------------------------
module ris_datapath
    import ris_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rec_in_t               rec,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_out_t              res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ris_cmd_t              cmd,
    output ris_sts_t              sts
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int EXT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // strcmp-style order over the nine name bytes: {less, greater}
    function automatic logic [1:0] name_order(input logic [NAME_W-1:0] a,
                                              input logic [NAME_W-1:0] b);
        logic       live;
        logic       lt;
        logic       gt;
        logic [7:0] ab;
        logic [7:0] bb;
        live = 1'b1;
        lt   = 1'b0;
        gt   = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            ab = a[NAME_W-1-8*i -: 8];
            bb = b[NAME_W-1-8*i -: 8];
            if (live && (ab != bb))
            begin
                lt = ab < bb;
                gt = ab > bb;
            end
            live = live && (ab == bb) && (ab != 8'd0);
        end
        return {lt, gt};
    endfunction

    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [CNT_W-1:0]  p_reg;
    logic [CNT_W-1:0]  p_next;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  k_next;
    logic              drop_reg;
    logic              drop_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic              sort_key_reg;
    logic              desc_reg;

    rec_t              new_reg;
    logic              last_reg;
    rec_t              rd_data_reg;
    res_out_t          res_reg;
    rec_t              store_reg [CAPACITY];

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] p_idx;
    logic [CNT_W-1:0]  fill_dec;
    logic [CNT_W-1:0]  p_dec2;
    logic [CNT_W-1:0]  k_inc;
    logic [EXT_W-1:0]  pos_ext;
    logic [1:0]        name_cmp;
    logic              key_lt;
    logic              key_gt;

    // Configuration, control counters, drop flag and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_key_reg  <= 1'b0;
            desc_reg      <= 1'b0;
            fill_reg      <= '0;
            p_reg         <= '0;
            k_reg         <= '0;
            drop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SORT_KEY:   sort_key_reg <= cfg_data[0];
                    REG_DESCENDING: desc_reg     <= cfg_data[0];
                    default:        sort_key_reg <= sort_key_reg;
                endcase
            end
            fill_reg      <= fill_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
            drop_reg      <= drop_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign fill_dec = fill_reg - CNT_W'(1);
    assign p_dec2   = p_reg - CNT_W'(2);
    assign k_inc    = k_reg + CNT_W'(1);
    assign p_idx    = p_reg[ADDR_W-1:0];

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clear_set)
            fill_next = '0;
        else if (cmd.place)
            fill_next = fill_reg + CNT_W'(1);

        p_next = p_reg;
        if (cmd.start_scan)
            p_next = fill_reg;
        else if (cmd.scan_step)
            p_next = p_reg - CNT_W'(1);

        k_next = k_reg;
        if (cmd.clear_set)
            k_next = '0;
        else if (cmd.emit_load)
            k_next = k_inc;

        drop_next = drop_reg;
        if (cmd.clear_set)
            drop_next = 1'b0;
        else if (cmd.set_drop)
            drop_next = 1'b1;

        res_valid_next = res_valid_reg;
        if (cmd.emit_load)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    // Read address: tail entry on scan start, next entry down while shifting, output entry in read-out
    always_comb
    begin
        rd_en   = cmd.start_scan || cmd.scan_step || cmd.emit_read;
        rd_addr = k_reg[ADDR_W-1:0];
        priority if (cmd.start_scan)
            rd_addr = fill_dec[ADDR_W-1:0];
        else if (cmd.scan_step)
            rd_addr = p_dec2[ADDR_W-1:0];
        else
            rd_addr = k_reg[ADDR_W-1:0];
    end

    // Store, item payload and result register
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
            store_reg[p_idx] <= rd_data_reg;
        else if (cmd.place)
            store_reg[p_idx] <= new_reg;

        if (rd_en)
            rd_data_reg <= store_reg[rd_addr];

        if (cmd.latch_in)
        begin
            new_reg.name_head <= rec.name_head;
            new_reg.name_tail <= rec.name_tail;
            new_reg.age       <= rec.age;
            new_reg.phone     <= rec.phone;
            last_reg          <= rec.is_last;
        end

        if (cmd.emit_load)
        begin
            res_reg.position      <= pos_ext[POS_W-1:0];
            res_reg.out_name_head <= rd_data_reg.name_head;
            res_reg.out_name_tail <= rd_data_reg.name_tail;
            res_reg.out_age       <= rd_data_reg.age;
            res_reg.out_phone     <= rd_data_reg.phone;
            res_reg.overflowed    <= drop_reg;
            res_reg.last_of_run   <= (k_inc == fill_reg);
        end
    end

    assign pos_ext = EXT_W'(k_inc);

    // New record against the entry just read
    assign name_cmp = name_order({new_reg.name_head, new_reg.name_tail},
                                 {rd_data_reg.name_head, rd_data_reg.name_tail});
    assign key_lt   = sort_key_reg ? name_cmp[1] : (new_reg.age < rd_data_reg.age);
    assign key_gt   = sort_key_reg ? name_cmp[0] : (new_reg.age > rd_data_reg.age);

    assign sts.full      = (fill_reg == CNT_W'(CAPACITY));
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.p_one     = (p_reg == CNT_W'(1));
    assign sts.ahead     = desc_reg ? key_gt : key_lt;
    assign sts.rec_last  = rec.is_last;
    assign sts.item_last = last_reg;
    assign sts.emit_last = (k_inc == fill_reg);
    assign sts.out_free  = !res_valid_reg || res_ready;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/record_insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// record_insertion_sorter: stable insertion sorter for contact records
// Collects a set of records in a sorted store and emits them ranked.
// ----------------------------------------------------------------------------
// Usage:
//   Offer records on rec / rec_valid / rec_ready; ranked results leave on
//   res / res_valid / res_ready. Both channels move an item when valid and
//   ready are high at a rising edge. Write sort_key (index 0) and descending
//   (index 1) through cfg_we / cfg_index / cfg_data while no set is open.
//   Each record is placed behind every stored record with an equal key, so
//   a set keeps arrival order among equal keys.
//   A record into an empty store goes straight to placement; otherwise the scan
//   starts at the tail and compares and moves one entry per cycle through the
//   single read port of the record store until the record finds its place.
//   A record offered to a full store is dropped and flags the set.
//   A record marked is_last is placed (or dropped when full), then the store is
//   read out, each entry read and then loaded; positions run from 1.
//   When the receiver stalls, the result register holds and the read-out
//   waits. After the last result is loaded the store is empty and records
//   are accepted again while that result still waits to be taken.
//   Reset empties the store, clears the drop flag and selects ascending age.
// ----------------------------------------------------------------------------
module record_insertion_sorter
    import ris_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rec_valid,
    output logic                  rec_ready,
    input  rec_in_t               rec,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_out_t              res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Commands down to the datapath, status back to the sequencer
    ris_cmd_t cmd;
    ris_sts_t sts;

    ris_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ris_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (rec),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== hw/rtl/ris_checker.sv =====
// ----------------------------------------------------------------------------
// ris_checker: port-level checks of the record insertion sorter
// Watches the two item channels and binds to the top level.
// ----------------------------------------------------------------------------
module ris_checker
    import ris_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     rec_valid,
    input logic     rec_ready,
    input rec_in_t  rec,
    input logic     res_valid,
    input logic     res_ready,
    input res_out_t res
);

    // A closing record starts the read-out, so no record follows at once
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_ready && rec.is_last |=> !rec_ready)
        else $error("record accepted straight after a closing record");

    // Mid-run, the block stays busy emitting
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res.last_of_run |=> !rec_ready)
        else $error("records accepted before the run finished");

    // Only the final result of a run may wait while records are taken
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        rec_ready && res_valid |-> res.last_of_run)
        else $error("pending result is not the end of its run while idle");

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result changed or dropped");

endmodule

bind record_insertion_sorter ris_checker u_ris_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
